### hdl/lru_cache_hit_tracker_macros.svh
// Assertion macros used by the checker file.
`ifndef LRU_CACHE_HIT_TRACKER_MACROS_SVH
`define LRU_CACHE_HIT_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUT_ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRUT_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

### hdl/lrut_pkg.sv
package lrut_pkg;

   localparam int PAGE_PORT_W = 32;
   localparam int COUNT_W     = 32;
   localparam int CSR_W       = 5;

   localparam logic [COUNT_W-1:0] CNT_MAX     = '1;
   localparam logic [CSR_W-1:0]   SLOTS_RESET = 5'd16;

   typedef struct packed {
      logic go;
      logic hit;
   } chain_type;

endpackage

### hdl/lru_cache_hit_tracker.sv
// LRU cache hit tracker.
// Each request transfer carries one page number. The block looks the page up in a
// recency-ordered row of SLOTS cells (cell 0 is most recent) and returns one response
// transfer with hit, evicted, evicted_page and the saturating hit and access totals.
// Configuration: csr_wr_data sets the number of slots in use (0 acts as 1, values above
// SLOTS act as SLOTS); write it only while no request is in flight.
// The response is registered and is valid in the cycle after the request transfer.
// Throughput: one access per cycle unless stalled. All cells compare in the same cycle
// and the shift decision ripples once along the cell row, so that chain sets the cycle time.
// A new request is taken while the response register drains in the same cycle;
// req_stall is high only while a response is held and rsp_stall is high.
// A stalled response holds its payload until it is transferred.
// Reset (synchronous, active high) empties the store, clears both totals, drops any
// pending response and sets the slots in use to 16.
module lru_cache_hit_tracker import lrut_pkg::*; #(
   parameter int SLOTS     = 16,
   parameter int PAGE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PAGE_PORT_W-1:0] req_page,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic                   rsp_evicted,
   output logic [PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [COUNT_W-1:0]     rsp_hit_total,
   output logic [COUNT_W-1:0]     rsp_access_total,
   input  logic                   csr_wr_en,
   input  logic [CSR_W-1:0]       csr_wr_data
);

   localparam int STORE_W = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
   localparam int OCC_W   = $clog2(SLOTS + 1);
   localparam int CMP_W   = (OCC_W > CSR_W) ? OCC_W : CSR_W;

   logic [CSR_W-1:0]       slots_ff;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [COUNT_W-1:0]     hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]     access_count_ff, access_count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff;
   logic                   rsp_evicted_ff;
   logic [PAGE_PORT_W-1:0] rsp_evicted_page_ff;
   logic [COUNT_W-1:0]     rsp_hit_total_ff;
   logic [COUNT_W-1:0]     rsp_access_total_ff;

   logic                   accept;
   logic                   full;
   logic                   hit;
   logic                   evict;
   logic [CSR_W-1:0]       limit;
   logic [STORE_W-1:0]     page_now;
   logic [PAGE_PORT_W-1:0] ev_word;

   chain_type              chain [SLOTS:0];
   logic [STORE_W-1:0]     ev_chain [SLOTS:0];
   logic [STORE_W-1:0]     page_q [SLOTS-1:0];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign page_now  = req_page[STORE_W-1:0];

   assign limit = (slots_ff == '0) ? CSR_W'(1) : slots_ff;
   assign full  = (occ_ff == OCC_W'(SLOTS)) || (CMP_W'(occ_ff) >= CMP_W'(limit));

   assign chain[0].go  = 1'b1;
   assign chain[0].hit = 1'b0;
   assign ev_chain[0]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic [STORE_W-1:0] prev_page;

      if (i == 0) begin : g_head
         assign prev_page = page_now;
      end else begin : g_body
         assign prev_page = page_q[i-1];
      end

      lrut_cell #(
         .W (STORE_W)
      ) u_cell (
         .clock     (clock),
         .update    (accept),
         .valid     (OCC_W'(i) < occ_ff),
         .tail      (occ_ff == OCC_W'(i + 1)),
         .full      (full),
         .page_in   (page_now),
         .prev_page (prev_page),
         .chain_in  (chain[i]),
         .ev_in     (ev_chain[i]),
         .page_out  (page_q[i]),
         .chain_out (chain[i+1]),
         .ev_out    (ev_chain[i+1])
      );
   end

   assign hit   = chain[SLOTS].hit;
   assign evict = !hit && full;

   always_comb begin
      ev_word = '0;
      if (evict) begin
         ev_word[STORE_W-1:0] = ev_chain[SLOTS];
      end
   end

   always_comb begin
      occ_in          = occ_ff;
      hit_count_in    = hit_count_ff;
      access_count_in = access_count_ff;
      if (accept) begin
         if (!hit && !full) begin
            occ_in = occ_ff + OCC_W'(1);
         end
         if (hit && (hit_count_ff != CNT_MAX)) begin
            hit_count_in = hit_count_ff + COUNT_W'(1);
         end
         if (access_count_ff != CNT_MAX) begin
            access_count_in = access_count_ff + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff        <= SLOTS_RESET;
         occ_ff          <= '0;
         hit_count_ff    <= '0;
         access_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slots_ff <= csr_wr_data;
         end
         occ_ff          <= occ_in;
         hit_count_ff    <= hit_count_in;
         access_count_ff <= access_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff          <= hit;
         rsp_evicted_ff      <= evict;
         rsp_evicted_page_ff <= ev_word;
         rsp_hit_total_ff    <= hit_count_in;
         rsp_access_total_ff <= access_count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_hit_total    = rsp_hit_total_ff;
   assign rsp_access_total = rsp_access_total_ff;

endmodule

### hdl/lrut_cell.sv
module lrut_cell import lrut_pkg::*; #(
   parameter int W = 32
) (
   input  logic          clock,
   input  logic          update,
   input  logic          valid,
   input  logic          tail,
   input  logic          full,
   input  logic [W-1:0]  page_in,
   input  logic [W-1:0]  prev_page,
   input  chain_type     chain_in,
   input  logic [W-1:0]  ev_in,
   output logic [W-1:0]  page_out,
   output chain_type     chain_out,
   output logic [W-1:0]  ev_out
);

   logic [W-1:0] page_ff;
   logic         match;

   assign match           = valid && (page_ff == page_in);
   assign chain_out.go    = chain_in.go && valid && !match && !(full && tail);
   assign chain_out.hit   = chain_in.hit || match;
   assign ev_out          = ev_in | (tail ? page_ff : '0);
   assign page_out        = page_ff;

   // A cell that is still on the shift path takes its neighbor's page; cell 0 takes the request page.
   always_ff @(posedge clock) begin
      if (update && chain_in.go) begin
         page_ff <= prev_page;
      end
   end

endmodule

### hdl/lrut_checker.sv
`include "lru_cache_hit_tracker_macros.svh"

module lrut_checker import lrut_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_hit,
   input logic                   rsp_evicted,
   input logic [PAGE_PORT_W-1:0] rsp_evicted_page,
   input logic [COUNT_W-1:0]     rsp_hit_total,
   input logic [COUNT_W-1:0]     rsp_access_total
);

   `LRUT_ASSERT_SAME(a_evict_excludes_hit, clock, reset, rsp_valid && rsp_evicted, !rsp_hit, "eviction reported on a hit")

   `LRUT_ASSERT_SAME(a_no_evict_zero_page, clock, reset, rsp_valid && !rsp_evicted, rsp_evicted_page == '0, "evicted page nonzero without eviction")

   `LRUT_ASSERT_SAME(a_hits_within_accesses, clock, reset, rsp_valid, (rsp_hit_total <= rsp_access_total) && (rsp_access_total != '0), "hit total exceeds access total")

   `LRUT_ASSERT_NEXT(a_stalled_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_evicted) && $stable(rsp_evicted_page) && $stable(rsp_hit_total) && $stable(rsp_access_total), "stalled response changed")

endmodule

bind lru_cache_hit_tracker lrut_checker u_lrut_checker (.*);
